// File: hdl/assert_macros.svh
// Assertion helper macros shared by the RTL modules.
// Expects clk and arst_n in the scope of the module that uses them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset
`define CHK_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("check failed");

// Next-cycle implication, checked outside reset
`define CHK_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("check failed");

`endif

// File: hdl/pqed_pkg.sv
// Shared types, codes and helpers of the palette quantizer.
// No dependencies.
package pqed_pkg;

	localparam int DEF_MAX_WIDTH  = 2048;
	localparam int DEF_MAX_COLORS = 256;

	// input command codes
	localparam logic CMD_PALETTE = 1'b0;
	localparam logic CMD_PIXEL   = 1'b1;

	// configuration register indexes
	localparam int CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_COLOR_COUNT   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_DITHER_ENABLE = 3'd3;
	localparam int CFG_DATA_W = 16;

	// configuration reset values
	localparam logic [11:0] RST_IMAGE_WIDTH  = 12'd1;
	localparam logic [15:0] RST_IMAGE_HEIGHT = 16'd1;
	localparam logic [8:0]  RST_COLOR_COUNT  = 9'd256;

	// distance above any real squared RGB distance
	localparam logic [17:0] DIST_INIT = 18'(3 * 256 * 256);

	typedef struct packed {
		logic       command;
		logic [7:0] entry_index;
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} in_item_t;

	typedef struct packed {
		logic [7:0] color_index;
		logic [7:0] out_red;
		logic [7:0] out_green;
		logic [7:0] out_blue;
		logic       end_of_frame;
	} out_item_t;

	typedef enum logic {
		KIND_PALETTE,
		KIND_PIXEL
	} item_kind_t;

	// classified item between front and back; rgb[0] red, [1] green, [2] blue
	typedef struct packed {
		item_kind_t      kind;
		logic [7:0]      entry_index;
		logic [2:0][7:0] rgb;
	} front_item_t;

	typedef struct packed {
		logic [11:0] image_width;
		logic [15:0] image_height;
		logic [8:0]  color_count;
		logic        dither_enable;
	} cfg_t;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_RDBUF,
		ST_ADJ,
		ST_SCAN,
		ST_DRAIN,
		ST_ERR,
		ST_WRA,
		ST_WRB,
		ST_OUT
	} back_state_t;

	// add a signed share to a pixel value, clamp to 0..255
	function automatic logic [7:0] add_clamp(input logic [7:0] p, input logic [7:0] d);
		logic signed [9:0] s;
		s = $signed({2'b00, p}) + $signed({{2{d[7]}}, d});
		if (s < 0)
			return 8'd0;
		else if (s > 10'sd255)
			return 8'd255;
		else
			return s[7:0];
	endfunction

endpackage

// File: hdl/pqed_ram.sv
// Generic single-port RAM with registered read.
// No dependencies.
module pqed_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we)
			mem[addr] <= wdata;
		rdata_q <= mem[addr];
	end

	assign rdata = rdata_q;
endmodule

// File: hdl/pqed_front.sv
// Front end: accepts input transactions, classifies them, queues them.
// Depends on pqed_pkg and assert_macros.svh.
`include "assert_macros.svh"
module pqed_front #(
	parameter int MAX_COLORS = pqed_pkg::DEF_MAX_COLORS
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  enable,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  pqed_pkg::in_item_t    in_data,
	output logic                  item_valid,
	input  logic                  item_ready,
	output pqed_pkg::front_item_t item
);
	import pqed_pkg::*;

	localparam int QDEPTH = 2;

	front_item_t q_q [QDEPTH];
	logic        wr_ptr_q, rd_ptr_q;
	logic [1:0]  count_q;
	front_item_t cls;
	logic        keep, enq, deq, accepted;

	// classify: palette writes past the palette are dropped here
	always_comb begin
		cls.kind        = (in_data.command == CMD_PIXEL) ? KIND_PIXEL : KIND_PALETTE;
		cls.entry_index = in_data.entry_index;
		cls.rgb         = {in_data.blue, in_data.green, in_data.red};
		keep = (in_data.command == CMD_PIXEL) || (32'(in_data.entry_index) < MAX_COLORS);
	end

	assign in_ready   = enable && (count_q != 2'(QDEPTH));
	assign accepted   = in_valid && in_ready;
	assign enq        = accepted && keep;
	assign item_valid = (count_q != 2'd0);
	assign deq        = item_valid && item_ready;
	assign item       = q_q[rd_ptr_q];

	// queue pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (enq)
				wr_ptr_q <= ~wr_ptr_q;
			if (deq)
				rd_ptr_q <= ~rd_ptr_q;
			count_q <= count_q + 2'(enq) - 2'(deq);
		end
	end

	// queue storage
	always_ff @(posedge clk) begin
		if (enq)
			q_q[wr_ptr_q] <= cls;
	end

	`CHK_SAME(a_count_bound, 1'b1, count_q <= 2'(QDEPTH))
	`CHK_SAME(a_no_take_when_off, !enable, !in_ready)
	`CHK_NEXT(a_enq_grows, enq && !deq, count_q == $past(count_q) + 2'd1)
endmodule

// File: hdl/pqed_back.sv
// Back end: palette writes, error-diffusion adjust, nearest-entry scan,
// error spreading and result register. Depends on pqed_pkg, pqed_ram,
// assert_macros.svh.
`include "assert_macros.svh"
module pqed_back #(
	parameter int MAX_WIDTH  = pqed_pkg::DEF_MAX_WIDTH,
	parameter int MAX_COLORS = pqed_pkg::DEF_MAX_COLORS
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  pqed_pkg::cfg_t        cfg,
	output logic                  ready_for_items,
	input  logic                  item_valid,
	output logic                  item_ready,
	input  pqed_pkg::front_item_t item,
	output logic                  out_valid,
	input  logic                  out_ready,
	output pqed_pkg::out_item_t   out_data
);
	import pqed_pkg::*;

	localparam int CW = $clog2(MAX_WIDTH);
	localparam int PW = $clog2(MAX_COLORS);

	back_state_t state_q, state_d;

	// geometry and position
	logic [CW-1:0] colpos_q, clr_q, w_m1, col;
	logic [15:0]   rowpos_q, h_m1, row;
	logic [PW-1:0] cc_m1;
	logic          last_col, last_row, dith, down_on;

	// carries
	logic [2:0][7:0] right_q, diag_q;

	// pixel work registers
	logic [2:0][7:0] cur_q, pix_q, adj;
	logic [2:0][7:0] best_rgb_q, rgb_s2;
	logic [2:0][7:0] sh7_q, sh5_q, sh3_q, sh1_q;
	logic [PW-1:0]   scan_q, idx_s1, idx_s2, best_idx_q;
	logic            v_s1, v_s2;
	logic [17:0]     dist_s2, ent_dist;
	logic [17:0]     best_dist_q;
	logic            out_valid_q, out_load;
	out_item_t       out_q;

	// memories
	logic            pal_we;
	logic [PW-1:0]   pal_addr;
	logic [23:0]     pal_wdata, pal_rdata;
	logic [2:0][7:0] pal_rgb;
	logic            a_we, b_we;
	logic [CW-1:0]   a_addr, b_addr;
	logic [2:0][1:0][7:0] a_wdata, a_rdata;
	logic [2:0][7:0] b_wdata, b_rdata;

	pqed_ram #(.WIDTH(24), .DEPTH(MAX_COLORS)) u_pal (
		.clk(clk), .we(pal_we), .addr(pal_addr), .wdata(pal_wdata), .rdata(pal_rdata)
	);
	pqed_ram #(.WIDTH(48), .DEPTH(MAX_WIDTH)) u_dlt_a (
		.clk(clk), .we(a_we), .addr(a_addr), .wdata(a_wdata), .rdata(a_rdata)
	);
	pqed_ram #(.WIDTH(24), .DEPTH(MAX_WIDTH)) u_dlt_b (
		.clk(clk), .we(b_we), .addr(b_addr), .wdata(b_wdata), .rdata(b_rdata)
	);

	// effective geometry, saturated position
	always_comb begin
		if (cfg.image_width == 12'd0)
			w_m1 = '0;
		else if (32'(cfg.image_width) > MAX_WIDTH)
			w_m1 = CW'(MAX_WIDTH - 1);
		else
			w_m1 = CW'(cfg.image_width - 12'd1);
		h_m1 = (cfg.image_height == 16'd0) ? 16'd0 : cfg.image_height - 16'd1;
		if (cfg.color_count == 9'd0)
			cc_m1 = '0;
		else if (32'(cfg.color_count) > MAX_COLORS)
			cc_m1 = PW'(MAX_COLORS - 1);
		else
			cc_m1 = PW'(cfg.color_count - 9'd1);
		col      = (colpos_q > w_m1) ? w_m1 : colpos_q;
		row      = (rowpos_q > h_m1) ? h_m1 : rowpos_q;
		last_col = (col == w_m1);
		last_row = (row == h_m1);
		dith     = cfg.dither_enable;
		down_on  = dith && !last_row;
	end

	// incoming pixel plus pending shares and right carry, when dithering is on
	always_comb begin
		for (int c = 0; c < 3; c++) begin
			if (dith) begin
				adj[c] = add_clamp(cur_q[c], a_rdata[c][0]);
				adj[c] = add_clamp(adj[c], a_rdata[c][1]);
				adj[c] = add_clamp(adj[c], b_rdata[c]);
				adj[c] = add_clamp(adj[c], right_q[c]);
			end else begin
				adj[c] = cur_q[c];
			end
		end
	end

	// squared distance of the entry read this cycle
	always_comb begin
		logic signed [8:0]  d;
		logic signed [17:0] sq;
		ent_dist = '0;
		pal_rgb = {pal_rdata[7:0], pal_rdata[15:8], pal_rdata[23:16]};
		for (int c = 0; c < 3; c++) begin
			d = $signed({1'b0, pal_rgb[c]}) - $signed({1'b0, pix_q[c]});
			sq = d * d;
			ent_dist = ent_dist + 18'(sq[16:0]);
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR: if (clr_q == CW'(MAX_WIDTH - 1)) state_d = ST_IDLE;
			ST_IDLE:  if (item_valid && item.kind == KIND_PIXEL) state_d = ST_RDBUF;
			ST_RDBUF: state_d = ST_ADJ;
			ST_ADJ:   state_d = ST_SCAN;
			ST_SCAN:  if (scan_q == cc_m1) state_d = ST_DRAIN;
			ST_DRAIN: if (!v_s1 && !v_s2) state_d = ST_ERR;
			ST_ERR:   state_d = ST_WRA;
			ST_WRA:   state_d = ST_WRB;
			ST_WRB:   state_d = ST_OUT;
			ST_OUT:   if (out_load) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	// memory control and handshakes
	always_comb begin
		item_ready      = (state_q == ST_IDLE);
		ready_for_items = (state_q != ST_CLEAR);
		out_load        = (state_q == ST_OUT) && (!out_valid_q || out_ready);
		pal_we    = (state_q == ST_IDLE) && item_valid && (item.kind == KIND_PALETTE);
		pal_addr  = pal_we ? PW'(item.entry_index) : scan_q;
		pal_wdata = {item.rgb[0], item.rgb[1], item.rgb[2]};
		a_we    = 1'b0;
		b_we    = 1'b0;
		a_addr  = col;
		b_addr  = col;
		a_wdata = '0;
		b_wdata = '0;
		case (state_q)
			ST_CLEAR: begin
				a_we   = 1'b1;
				b_we   = 1'b1;
				a_addr = clr_q;
				b_addr = clr_q;
			end
			ST_WRA: begin
				a_we = 1'b1;
				b_we = 1'b1;
				if (down_on) begin
					for (int c = 0; c < 3; c++)
						a_wdata[c] = {sh5_q[c], diag_q[c]};
				end
			end
			ST_WRB: begin
				b_we    = down_on && (col != '0);
				b_addr  = col - 1'b1;
				b_wdata = sh3_q;
			end
			default: begin
				a_we = 1'b0;
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			colpos_q    <= '0;
			rowpos_q    <= '0;
			right_q     <= '0;
			diag_q      <= '0;
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR)
				clr_q <= clr_q + 1'b1;
			v_s1 <= (state_q == ST_SCAN);
			v_s2 <= v_s1;
			if (out_load) begin
				for (int c = 0; c < 3; c++) begin
					right_q[c] <= (dith && !last_col) ? sh7_q[c] : 8'd0;
					diag_q[c]  <= (down_on && !last_col) ? sh1_q[c] : 8'd0;
				end
				colpos_q <= last_col ? '0 : col + 1'b1;
				if (last_col)
					rowpos_q <= last_row ? 16'd0 : row + 16'd1;
				else
					rowpos_q <= row;
			end
			if (out_load)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		logic signed [8:0]  e;
		logic signed [12:0] e7, e5, e3;
		if (state_q == ST_IDLE)
			cur_q <= item.rgb;
		if (state_q == ST_ADJ) begin
			pix_q      <= adj;
			scan_q     <= '0;
			best_idx_q <= '0;
			best_rgb_q <= '0;
		end else if (state_q == ST_SCAN) begin
			scan_q <= scan_q + 1'b1;
		end
		// scan pipeline
		idx_s1  <= scan_q;
		idx_s2  <= idx_s1;
		dist_s2 <= ent_dist;
		rgb_s2  <= pal_rgb;
		if (v_s2 && (dist_s2 < best_dist_q)) begin
			best_idx_q <= idx_s2;
			best_rgb_q <= rgb_s2;
		end
		// error shares, floor of k*e/16
		if (state_q == ST_ERR) begin
			for (int c = 0; c < 3; c++) begin
				e  = $signed({1'b0, pix_q[c]}) - $signed({1'b0, best_rgb_q[c]});
				e7 = ($signed(13'(e)) <<< 3) - 13'(e);
				e5 = ($signed(13'(e)) <<< 2) + 13'(e);
				e3 = ($signed(13'(e)) <<< 1) + 13'(e);
				sh7_q[c] <= 8'(e7 >>> 4);
				sh5_q[c] <= 8'(e5 >>> 4);
				sh3_q[c] <= 8'(e3 >>> 4);
				sh1_q[c] <= 8'(e >>> 4);
			end
		end
		if (out_load) begin
			out_q.color_index  <= 8'(best_idx_q);
			out_q.out_red      <= best_rgb_q[0];
			out_q.out_green    <= best_rgb_q[1];
			out_q.out_blue     <= best_rgb_q[2];
			out_q.end_of_frame <= last_col && last_row;
		end
	end

	// running best distance
	always_ff @(posedge clk) begin
		if (state_q == ST_ADJ)
			best_dist_q <= DIST_INIT;
		else if (v_s2 && (dist_s2 < best_dist_q))
			best_dist_q <= dist_s2;
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	`CHK_SAME(a_no_pop_in_clear, state_q == ST_CLEAR, !item_ready)
	`CHK_SAME(a_scan_in_range, state_q == ST_SCAN, scan_q <= cc_m1)
	`CHK_SAME(a_pipe_in_scan, v_s2, state_q == ST_SCAN || state_q == ST_DRAIN)
endmodule

// File: hdl/palette_quantizer_error_diffusion_top.sv
// Channel    | Direction | Handshake              | Payload
// in         | input     | in_valid / in_ready    | in_data (in_item_t)
// out        | output    | out_valid / out_ready  | out_data (out_item_t)
// cfg        | input     | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// A pixel's processing time is set by the palette scan, which reads one entry per
// cycle from the single-port palette RAM for N entries, N being color_count held
// to 1..MAX_COLORS; a pixel also waits while a result still sits in the output
// register. A palette write is taken in the idle state.
// After reset a clearing pass over all MAX_WIDTH entries zeroes the row delta RAMs;
// no input transaction is taken during it, configuration writes are.
// The front queue holds two transactions, so input is still taken while a result
// waits in the output register, until the queue is full.
// Depends on pqed_pkg, pqed_front, pqed_back.
module palette_quantizer_error_diffusion_top #(
	parameter int MAX_WIDTH  = pqed_pkg::DEF_MAX_WIDTH,
	parameter int MAX_COLORS = pqed_pkg::DEF_MAX_COLORS
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  pqed_pkg::in_item_t                   in_data,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output pqed_pkg::out_item_t                  out_data,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [pqed_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [pqed_pkg::CFG_DATA_W-1:0]      cfg_data
);
	import pqed_pkg::*;

	cfg_t        cfg_q;
	logic        enable;
	logic        item_valid, item_ready;
	front_item_t item;

	assign cfg_ready = 1'b1;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.image_width   <= RST_IMAGE_WIDTH;
			cfg_q.image_height  <= RST_IMAGE_HEIGHT;
			cfg_q.color_count   <= RST_COLOR_COUNT;
			cfg_q.dither_enable <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_IMAGE_WIDTH:   cfg_q.image_width   <= cfg_data[11:0];
				REG_IMAGE_HEIGHT:  cfg_q.image_height  <= cfg_data[15:0];
				REG_COLOR_COUNT:   cfg_q.color_count   <= cfg_data[8:0];
				REG_DITHER_ENABLE: cfg_q.dither_enable <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	pqed_front #(.MAX_COLORS(MAX_COLORS)) u_front (
		.clk(clk), .arst_n(arst_n), .enable(enable),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.item_valid(item_valid), .item_ready(item_ready), .item(item)
	);

	pqed_back #(.MAX_WIDTH(MAX_WIDTH), .MAX_COLORS(MAX_COLORS)) u_back (
		.clk(clk), .arst_n(arst_n), .cfg(cfg_q), .ready_for_items(enable),
		.item_valid(item_valid), .item_ready(item_ready), .item(item),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
	);
endmodule

// File: verif/tb_palette_quantizer_error_diffusion_top.sv
// Testbench for the palette quantizer with error diffusion: random palettes,
// pixel frames and register settings, checked against an in-bench predictor.
// Depends on pqed_pkg and palette_quantizer_error_diffusion_top.
`timescale 1ns / 1ps

module tb_palette_quantizer_error_diffusion_top;
	import pqed_pkg::*;

	localparam int MAXW        = 2048;
	localparam int MAXC        = 256;
	localparam int CYCLE_LIMIT = 2000000;
	localparam int SETTLE      = 300;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  in_valid = 1'b0;
	logic                  in_ready;
	in_item_t              in_data = '0;
	logic                  out_valid;
	logic                  out_ready = 1'b0;
	out_item_t             out_data;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	palette_quantizer_error_diffusion_top dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// predictor state
	logic [23:0]      palette_mem [MAXC];
	logic [2:0][7:0]  row_shares [3][MAXW];
	logic [2:0][7:0]  right_share;
	logic [2:0][7:0]  diag_share;
	int unsigned      col_pos, row_pos;
	logic [11:0]      img_width;
	logic [15:0]      img_height;
	logic [8:0]       palette_size;
	logic             dither_on;

	in_item_t  pending_items [$];
	out_item_t expected_colors [$];
	int        mismatches = 0;
	int        accepted_inputs = 0;
	int        gap_left = 0;
	int        stall_left = 0;
	int        hold_left = 0;
	bit        hold_done = 1'b0;
	int        cycle_count = 0;

	function automatic logic [7:0] clamp_add(input int p, input logic [7:0] d);
		int s;
		s = p + int'($signed(d));
		return (s < 0) ? 8'd0 : (s > 255) ? 8'd255 : 8'(s);
	endfunction

	function automatic logic [7:0] share16(input int n);
		return 8'(n >>> 4);
	endfunction

	// nearest entry search plus diffusion update for one pixel
	function automatic void quantize_pixel(input in_item_t it);
		int unsigned w, h, cc, col, row, best, bestd, d;
		bit last_col, last_row;
		int px [3];
		int pc [3];
		int e, dr, dg, db;
		logic [2:0][7:0] new_right, new_diag;
		out_item_t res;
		w = (img_width == 0) ? 1 : img_width;
		if (w > MAXW) w = MAXW;
		h = (img_height == 0) ? 1 : img_height;
		cc = (palette_size == 0) ? 1 : palette_size;
		if (cc > MAXC) cc = MAXC;
		col = (col_pos < w) ? col_pos : w - 1;
		row = (row_pos < h) ? row_pos : h - 1;
		last_col = (col + 1 >= w);
		last_row = (row + 1 >= h);
		px[0] = it.red; px[1] = it.green; px[2] = it.blue;
		if (dither_on) begin
			for (int ch = 0; ch < 3; ch++) begin
				px[ch] = clamp_add(px[ch], row_shares[ch][col][0]);
				px[ch] = clamp_add(px[ch], row_shares[ch][col][1]);
				px[ch] = clamp_add(px[ch], row_shares[ch][col][2]);
				px[ch] = clamp_add(px[ch], right_share[ch]);
			end
		end
		best = 0;
		bestd = 3 * 256 * 256;
		for (int j = 0; j < cc; j++) begin
			dr = int'(palette_mem[j][23:16]) - px[0];
			dg = int'(palette_mem[j][15:8]) - px[1];
			db = int'(palette_mem[j][7:0]) - px[2];
			d = dr * dr + dg * dg + db * db;
			if (d < bestd) begin
				bestd = d;
				best = j;
			end
		end
		pc[0] = palette_mem[best][23:16];
		pc[1] = palette_mem[best][15:8];
		pc[2] = palette_mem[best][7:0];
		new_right = '0;
		new_diag = '0;
		for (int ch = 0; ch < 3; ch++) begin
			if (dither_on) begin
				e = px[ch] - pc[ch];
				if (!last_row) begin
					row_shares[ch][col] = '0;
					row_shares[ch][col][0] = diag_share[ch];
					row_shares[ch][col][1] = share16(5 * e);
					if (col > 0) row_shares[ch][col - 1][2] = share16(3 * e);
					if (!last_col) new_diag[ch] = share16(e);
				end else begin
					row_shares[ch][col] = '0;
				end
				if (!last_col) new_right[ch] = share16(7 * e);
			end else begin
				row_shares[ch][col] = '0;
			end
		end
		right_share = new_right;
		diag_share = new_diag;
		res.end_of_frame = 1'b0;
		if (last_col) begin
			col_pos = 0;
			if (last_row) begin
				row_pos = 0;
				res.end_of_frame = 1'b1;
			end else begin
				row_pos = row + 1;
			end
		end else begin
			col_pos = col + 1;
			row_pos = row;
		end
		res.color_index = 8'(best);
		res.out_red = 8'(pc[0]);
		res.out_green = 8'(pc[1]);
		res.out_blue = 8'(pc[2]);
		expected_colors = {expected_colors, res};
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(99);
		if (r < 65) return 0;
		if (r < 93) return $urandom_range(3, 1);
		return $urandom_range(40, 10);
	endfunction

	// input driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!(in_valid && !in_ready)) begin
			if (in_valid) begin
				accepted_inputs <= accepted_inputs + 1;
				if (in_data.command == CMD_PIXEL)
					quantize_pixel(in_data);
				else
					palette_mem[in_data.entry_index] = {in_data.red, in_data.green, in_data.blue};
			end
			if (gap_left > 0) begin
				gap_left <= gap_left - 1;
				in_valid <= 1'b0;
			end else if (pending_items.size() > 0) begin
				in_data <= pending_items.pop_front();
				in_valid <= 1'b1;
				gap_left <= pick_gap();
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// long receiver hold once the stream is under way
	always @(posedge clk) begin
		if (hold_left > 0)
			hold_left <= hold_left - 1;
		else if (!hold_done && accepted_inputs >= 400) begin
			hold_left <= 3000;
			hold_done <= 1'b1;
		end
	end

	// output ready with random stalls
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else if (hold_left > 0) begin
			out_ready <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
			stall_left <= pick_gap();
		end
	end

	// result monitor
	always @(posedge clk) begin
		out_item_t want;
		if (arst_n && out_valid && out_ready) begin
			if (expected_colors.size() == 0) begin
				mismatches <= mismatches + 1;
				if (mismatches < 10)
					$display("unexpected result transaction %p", out_data);
			end else begin
				want = expected_colors.pop_front();
				if (out_data.color_index !== want.color_index ||
				    out_data.out_red !== want.out_red ||
				    out_data.out_green !== want.out_green ||
				    out_data.out_blue !== want.out_blue ||
				    out_data.end_of_frame !== want.end_of_frame) begin
					mismatches <= mismatches + 1;
					if (mismatches < 10)
						$display("mismatch: expected %p, got %p", want, out_data);
				end
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("[palette_quantizer_error_diffusion_top] ERROR");
			$finish;
		end
	end

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= CFG_DATA_W'(val);
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_IMAGE_WIDTH:   img_width = 12'(val);
			REG_IMAGE_HEIGHT:  img_height = 16'(val);
			REG_COLOR_COUNT:   palette_size = 9'(val);
			REG_DITHER_ENABLE: dither_on = val[0];
			default: ;
		endcase
		cfg_valid <= 1'b0;
	endtask

	task automatic wait_idle();
		wait (pending_items.size() == 0 && !in_valid && expected_colors.size() == 0);
		repeat (SETTLE) @(posedge clk);
	endtask

	function automatic in_item_t make_item(input logic cmd, input int idx,
	                                       input int r, input int g, input int b);
		in_item_t it;
		it.command = cmd;
		it.entry_index = 8'(idx);
		it.red = 8'(r);
		it.green = 8'(g);
		it.blue = 8'(b);
		return it;
	endfunction

	// append one input transaction to the driver's queue
	function automatic void queue_item(input in_item_t it);
		pending_items = {pending_items, it};
	endfunction

	function automatic int pick_channel();
		int r;
		r = $urandom_range(9);
		return (r == 0) ? 0 : (r == 1) ? 255 : $urandom_range(255);
	endfunction

	function automatic int pick_width();
		case ($urandom_range(9))
			0: return 0;
			1: return 1;
			2: return 2048;
			3: return 4095;
			default: return $urandom_range(16, 2);
		endcase
	endfunction

	function automatic int pick_height();
		case ($urandom_range(9))
			0: return 0;
			1: return 1;
			2: return 65535;
			default: return $urandom_range(6, 2);
		endcase
	endfunction

	function automatic int pick_colors();
		case ($urandom_range(9))
			0: return 0;
			1: return 1;
			2: return 256;
			3: return $urandom_range(511, 257);
			default: return $urandom_range(32, 2);
		endcase
	endfunction

	initial begin
		for (int c = 0; c < 3; c++)
			for (int x = 0; x < MAXW; x++) row_shares[c][x] = '0;
		for (int j = 0; j < MAXC; j++) palette_mem[j] = '0;
		right_share = '0;
		diag_share = '0;
		col_pos = 0;
		row_pos = 0;
		img_width = RST_IMAGE_WIDTH;
		img_height = RST_IMAGE_HEIGHT;
		palette_size = RST_COLOR_COUNT;
		dither_on = 1'b0;
		repeat (10) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		// directed: full palette, extremes, a tie between two equal entries
		write_reg(REG_IMAGE_WIDTH, 2);
		write_reg(REG_IMAGE_HEIGHT, 2);
		write_reg(REG_COLOR_COUNT, 256);
		write_reg(REG_DITHER_ENABLE, 1);
		for (int j = 0; j < MAXC; j++)
			queue_item(make_item(CMD_PALETTE, j, $urandom_range(255),
				$urandom_range(255), $urandom_range(255)));
		queue_item(make_item(CMD_PALETTE, 0, 0, 0, 0));
		queue_item(make_item(CMD_PALETTE, 255, 255, 255, 255));
		queue_item(make_item(CMD_PALETTE, 10, 77, 140, 200));
		queue_item(make_item(CMD_PALETTE, 11, 77, 140, 200));
		queue_item(make_item(CMD_PIXEL, 0, 0, 0, 0));
		queue_item(make_item(CMD_PIXEL, 0, 255, 255, 255));
		queue_item(make_item(CMD_PIXEL, 0, 77, 140, 200));
		queue_item(make_item(CMD_PIXEL, 0, 255, 0, 128));
		queue_item(make_item(CMD_PIXEL, 0, 1, 254, 0));
		queue_item(make_item(CMD_PIXEL, 0, 200, 3, 90));
		wait_idle();

		// dithering off clears carries, then widen the image mid-frame
		write_reg(REG_DITHER_ENABLE, 0);
		write_reg(REG_IMAGE_WIDTH, 3);
		for (int k = 0; k < 4; k++)
			queue_item(make_item(CMD_PIXEL, 0, pick_channel(),
				pick_channel(), pick_channel()));
		wait_idle();

		// random phases
		for (int ph = 0; ph < 10; ph++) begin
			write_reg(REG_IMAGE_WIDTH, pick_width());
			write_reg(REG_IMAGE_HEIGHT, pick_height());
			write_reg(REG_COLOR_COUNT, (ph == 9) ? 256 : pick_colors());
			write_reg(REG_DITHER_ENABLE, ($urandom_range(3) != 0));
			for (int k = 0; k < 98; k++) begin
				if ($urandom_range(9) == 0)
					queue_item(make_item(CMD_PALETTE, $urandom_range(255),
						pick_channel(), pick_channel(), pick_channel()));
				queue_item(make_item(CMD_PIXEL, $urandom_range(255),
					pick_channel(), pick_channel(), pick_channel()));
			end
			wait_idle();
		end

		if (mismatches == 0)
			$display("[palette_quantizer_error_diffusion_top] OK");
		else
			$display("[palette_quantizer_error_diffusion_top] ERROR");
		$finish;
	end

endmodule

// File: filelist.f
+incdir+hdl
hdl/pqed_pkg.sv
hdl/pqed_ram.sv
hdl/pqed_front.sv
hdl/pqed_back.sv
hdl/palette_quantizer_error_diffusion_top.sv
verif/tb_palette_quantizer_error_diffusion_top.sv
